FILE: design/assert_macros.svh
// Assertion helpers shared by the RTL. Empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

FILE: design/ase_pkg.sv
`default_nettype none

package ase_pkg;

  localparam int unsigned PC_W        = 24;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned OPC_W       = 8;
  localparam int unsigned LADDR_W     = 8;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 128;

  typedef enum logic [OPC_W-1:0] {
    OP_LDC  = 8'd0,
    OP_ADC  = 8'd1,
    OP_LDL  = 8'd2,
    OP_STL  = 8'd3,
    OP_LDNL = 8'd4,
    OP_STNL = 8'd5,
    OP_ADD  = 8'd6,
    OP_SUB  = 8'd7,
    OP_SHL  = 8'd8,
    OP_SHR  = 8'd9,
    OP_ADJ  = 8'd10,
    OP_A2SP = 8'd11,
    OP_SP2A = 8'd12,
    OP_CALL = 8'd13,
    OP_RET  = 8'd14,
    OP_BRZ  = 8'd15,
    OP_BRLZ = 8'd16,
    OP_BR   = 8'd17,
    OP_HALT = 8'd18
  } opcode_e;

  typedef struct packed {
    logic              halt;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] sp;
    logic [PC_W-1:0]   pc;
  } arch_state_t;

  typedef struct packed {
    logic              mode;
    logic [OPC_W-1:0]  opcode;
    logic [PC_W-1:0]   operand;
    logic [DATA_W-1:0] load_data;
  } item_t;

endpackage

`default_nettype wire

FILE: design/ase_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read port.
module ase_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/ase_exec.sv
`default_nettype none

// Execute stage: next architectural state and memory write for one item.
module ase_exec (
  input  wire ase_pkg::arch_state_t           st_i,
  input  wire ase_pkg::item_t                 item_i,
  input  wire logic [ase_pkg::DATA_W-1:0]     mem_rdata_i,
  input  wire logic                           addr_fault_i,
  input  wire logic [ase_pkg::PC_W-1:0]       prog_len_i,
  output ase_pkg::arch_state_t                st_o,
  output logic                                mem_we_o,
  output logic      [ase_pkg::DATA_W-1:0]     mem_wdata_o,
  output logic                                fault_o
);
  import ase_pkg::*;

  logic [DATA_W-1:0] opnd_sx;
  logic [PC_W-1:0]   pc_inc;
  logic [PC_W-1:0]   pc_rel;
  logic [PC_W-1:0]   npc;

  assign opnd_sx = {{(DATA_W-PC_W){item_i.operand[PC_W-1]}}, item_i.operand};
  assign pc_inc  = st_i.pc + PC_W'(1);
  assign pc_rel  = st_i.pc + item_i.operand;

  always_comb begin
    st_o        = st_i;
    mem_we_o    = 1'b0;
    mem_wdata_o = item_i.load_data;
    fault_o     = 1'b0;
    npc         = pc_inc;
    if (item_i.mode) begin
      // preload: memory word only, works even when halted
      mem_we_o = 1'b1;
      fault_o  = addr_fault_i;
    end else if (!st_i.halt) begin
      if (st_i.pc >= prog_len_i) begin
        st_o.halt = 1'b1;
      end else begin
        case (opcode_e'(item_i.opcode))
          OP_LDC: begin
            st_o.b = st_i.a;
            st_o.a = opnd_sx;
          end
          OP_ADC: st_o.a = st_i.a + opnd_sx;
          OP_LDL: begin
            st_o.b  = st_i.a;
            st_o.a  = mem_rdata_i;
            fault_o = addr_fault_i;
          end
          OP_STL: begin
            mem_we_o    = 1'b1;
            mem_wdata_o = st_i.a;
            st_o.a      = st_i.b;
            fault_o     = addr_fault_i;
          end
          OP_LDNL: begin
            st_o.a  = mem_rdata_i;
            fault_o = addr_fault_i;
          end
          OP_STNL: begin
            mem_we_o    = 1'b1;
            mem_wdata_o = st_i.b;
            fault_o     = addr_fault_i;
          end
          OP_ADD:  st_o.a = st_i.a + st_i.b;
          OP_SUB:  st_o.a = st_i.b - st_i.a;
          OP_SHL:  st_o.a = st_i.b << st_i.a[4:0];
          OP_SHR:  st_o.a = DATA_W'($signed(st_i.b) >>> st_i.a[4:0]);
          OP_ADJ:  st_o.sp = st_i.sp + opnd_sx;
          OP_A2SP: begin
            st_o.sp = st_i.a;
            st_o.a  = st_i.b;
          end
          OP_SP2A: begin
            st_o.b = st_i.a;
            st_o.a = st_i.sp;
          end
          OP_CALL: begin
            st_o.b = st_i.a;
            st_o.a = {{(DATA_W-PC_W){1'b0}}, st_i.pc};
            npc    = pc_rel;
          end
          OP_RET: begin
            npc    = st_i.a[PC_W-1:0] + PC_W'(1);
            st_o.a = st_i.b;
          end
          OP_BRZ: begin
            if (st_i.a == '0) begin
              npc = pc_rel;
            end
          end
          OP_BRLZ: begin
            if (st_i.a[DATA_W-1]) begin
              npc = pc_rel;
            end
          end
          OP_BR: npc = pc_rel;
          OP_HALT: begin
            npc       = st_i.pc;
            st_o.halt = 1'b1;
          end
          default: ;
        endcase
        st_o.pc = npc;
        if (npc >= prog_len_i) begin
          st_o.halt = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/accumulator_stack_cpu_execute_top.sv
// Accumulator/stack machine, one instruction or memory preload per item.
// An accepted item is registered in the execute stage, and its result then in the output register.
// Throughput: one item per clock while the output is not stalled; the data memory read of the next
// item overlaps the execute/write-back of the previous one (register and memory forwarding).
// Reset: control registers reset at once (program_length to all ones); a clearing pass
// then zeroes the data memory, with s_axis_tready_o low (configuration writes still taken).
`default_nettype none
`include "assert_macros.svh"

module accumulator_stack_cpu_execute_top #(
  parameter int unsigned MEM_DEPTH = 256  // power of two, 16..65536
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration: program_length
  input  wire logic                                cfg_we_i,
  input  wire logic [ase_pkg::PC_W-1:0]            cfg_wdata_i,
  // input items
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // [7:0] opcode, [31:8] operand, [39:32] load_address, [71:40] load_data
  input  wire logic [ase_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // [0] mode
  input  wire logic [0:0]                          s_axis_tuser_i,
  // result items
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // [23:0] next_pc, [55:24] stack_pointer, [87:56] reg_a, [119:88] reg_b,
  // [120] halted, [121] address_fault, [127:122] zero
  output logic      [ase_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);
  import ase_pkg::*;

  localparam int unsigned AW = $clog2(MEM_DEPTH);

  // ---------------------------------------------------------------- input unpack
  item_t              in_item;
  logic [LADDR_W-1:0] in_laddr;

  assign in_item.mode      = s_axis_tuser_i[0];
  assign in_item.opcode    = s_axis_tdata_i[7:0];
  assign in_item.operand   = s_axis_tdata_i[31:8];
  assign in_item.load_data = s_axis_tdata_i[71:40];
  assign in_laddr          = s_axis_tdata_i[39:32];

  // ---------------------------------------------------------------- registers
  logic [PC_W-1:0]   prog_len_q;
  arch_state_t       st_q;
  logic              clearing_q, clearing_d;
  logic [AW-1:0]     clr_idx_q;

  // execute stage (item whose memory read is in flight)
  logic              s2_vld_q, s2_vld_d;
  item_t             s2_item_q;
  logic [AW-1:0]     s2_idx_q;
  logic              s2_afault_q;
  logic              fwd_q;
  logic [DATA_W-1:0] fwd_data_q;

  // output register
  logic              out_vld_q, out_vld_d;
  arch_state_t       out_st_q;
  logic              out_fault_q;

  // ---------------------------------------------------------------- handshake
  logic s2_adv;
  logic in_acc;

  assign s2_adv          = s2_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !clearing_q && (!s2_vld_q || s2_adv);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------------------------------------------------------- execute
  arch_state_t       ex_st;
  logic              ex_we;
  logic [DATA_W-1:0] ex_wdata;
  logic              ex_fault;
  logic [DATA_W-1:0] ram_rdata;
  logic [DATA_W-1:0] mem_data;

  assign mem_data = fwd_q ? fwd_data_q : ram_rdata;

  ase_exec u_exec (
    .st_i         (st_q),
    .item_i       (s2_item_q),
    .mem_rdata_i  (mem_data),
    .addr_fault_i (s2_afault_q),
    .prog_len_i   (prog_len_q),
    .st_o         (ex_st),
    .mem_we_o     (ex_we),
    .mem_wdata_o  (ex_wdata),
    .fault_o      (ex_fault)
  );

  // ---------------------------------------------------------------- address stage
  // State seen by the incoming item: the retiring item's result when it retires now.
  arch_state_t       view_st;
  logic [DATA_W-1:0] addr_base;
  logic [DATA_W-1:0] exec_addr;
  logic [AW-1:0]     pl_idx;
  logic              pl_fault;
  logic [AW-1:0]     rd_idx;
  logic              rd_fault;
  logic              is_sp_rel;

  assign view_st   = s2_adv ? ex_st : st_q;
  assign is_sp_rel = (in_item.opcode == OP_LDL) || (in_item.opcode == OP_STL);
  assign addr_base = is_sp_rel ? view_st.sp : view_st.a;
  assign exec_addr = addr_base + {{(DATA_W-PC_W){in_item.operand[PC_W-1]}}, in_item.operand};

  if (AW >= LADDR_W) begin : g_pl_wide
    assign pl_idx   = AW'(in_laddr);
    assign pl_fault = 1'b0;
  end else begin : g_pl_narrow
    assign pl_idx   = in_laddr[AW-1:0];
    assign pl_fault = |in_laddr[LADDR_W-1:AW];
  end

  assign rd_idx   = in_item.mode ? pl_idx : exec_addr[AW-1:0];
  assign rd_fault = in_item.mode ? pl_fault : (|exec_addr[DATA_W-1:AW]);

  // ---------------------------------------------------------------- data memory
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              wr_now;

  assign wr_now    = s2_adv && ex_we;
  assign mem_we    = clearing_q || wr_now;
  assign mem_waddr = clearing_q ? clr_idx_q : s2_idx_q;
  assign mem_wdata = clearing_q ? '0 : ex_wdata;

  ase_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_DEPTH)
  ) u_dmem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (in_acc),
    .raddr_i (rd_idx),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- control
  always_comb begin
    clearing_d = clearing_q;
    if (clearing_q && (clr_idx_q == AW'(MEM_DEPTH - 1))) begin
      clearing_d = 1'b0;
    end
    s2_vld_d = in_acc ? 1'b1 : (s2_adv ? 1'b0 : s2_vld_q);
    out_vld_d = s2_adv ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_len_q <= '1;
      st_q       <= '0;
      clearing_q <= 1'b1;
      clr_idx_q  <= '0;
      s2_vld_q   <= 1'b0;
      fwd_q      <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        prog_len_q <= cfg_wdata_i;
      end
      if (s2_adv) begin
        st_q <= ex_st;
      end
      clearing_q <= clearing_d;
      if (clearing_q) begin
        clr_idx_q <= clr_idx_q + AW'(1);
      end
      s2_vld_q  <= s2_vld_d;
      out_vld_q <= out_vld_d;
      if (in_acc) begin
        // write to the same word in this cycle is not seen by the RAM read
        fwd_q <= wr_now && (s2_idx_q == rd_idx);
      end else if (s2_adv) begin
        fwd_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s2_item_q   <= in_item;
      s2_idx_q    <= rd_idx;
      s2_afault_q <= rd_fault;
      fwd_data_q  <= ex_wdata;
    end
    if (s2_adv) begin
      out_st_q    <= ex_st;
      out_fault_q <= ex_fault;
    end
  end

  // ---------------------------------------------------------------- output
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'b0, out_fault_q, out_st_q.halt, out_st_q.b, out_st_q.a,
                            out_st_q.sp, out_st_q.pc};

  // ---------------------------------------------------------------- checks
  `ASSERT_PROP(a_halt_sticky, clk_i, rst_ni, st_q.halt |=> st_q.halt, "halt flag cleared")
  `ASSERT_PROP(a_pc_frozen, clk_i, rst_ni, st_q.halt |=> $stable(st_q.pc), "PC moved while halted")
  `ASSERT_NEVER(a_busy_clear, clk_i, rst_ni, clearing_q && s2_vld_q, "item during memory clear")
  `ASSERT_NEVER(a_fwd_orphan, clk_i, rst_ni, fwd_q && !s2_vld_q, "forward flag without item")

endmodule

`default_nettype wire
